// File: src/humidity_temp_frame_decoder_defines.svh
// assertion macros for the humidity and temperature frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HTFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/htfd_pkg.sv
// shared types, constants and crc function of the frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions within a reply frame
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;
  localparam logic [2:0] FRAME_BYTES  = 3'd6;

  // conversion constants, hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [16:0] WORD_MAX    = 17'd65535;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        crc_fail;
  } frame_t;

  // one byte through the msb-first crc-8, eight shift steps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/htfd_frame.sv
// byte position tracking, crc check and word assembly of a reply frame
`timescale 1ns / 1ps

module htfd_frame
  import htfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       fr_valid,
  output frame_t     fr_data,
  input  logic       fr_take
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic        fail_r, fail_nxt;
  logic        fr_valid_r, fr_valid_nxt;
  frame_t      fr_data_r, fr_data_nxt;

  logic       accept;
  logic [2:0] pos;
  logic [7:0] crc_base;
  logic       fail_base;

  assign in_ready = !fr_valid_r || fr_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos       = (in_start || pos_r >= FRAME_BYTES) ? POS_TEMP_HI : pos_r;
    crc_base  = (pos == POS_TEMP_HI) ? CRC_INIT : crc_r;
    fail_base = (pos == POS_TEMP_HI) ? 1'b0 : fail_r;

    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    temp_nxt     = temp_r;
    hum_nxt      = hum_r;
    fail_nxt     = fail_r;
    fr_data_nxt  = fr_data_r;
    fr_valid_nxt = fr_take ? 1'b0 : fr_valid_r;

    if (accept) begin
      crc_nxt  = crc8_step(crc_base, in_byte);
      fail_nxt = fail_base;
      unique case (pos) inside
        POS_TEMP_HI: temp_nxt = {in_byte, temp_r[7:0]};
        POS_TEMP_LO: temp_nxt = {temp_r[15:8], in_byte};
        POS_HUM_HI:  hum_nxt  = {in_byte, hum_r[7:0]};
        POS_HUM_LO:  hum_nxt  = {hum_r[15:8], in_byte};
        POS_TEMP_CRC, POS_HUM_CRC: begin
          fail_nxt = fail_base | (crc_base != in_byte);
          crc_nxt  = CRC_INIT;
        end
        default: crc_nxt = CRC_INIT;
      endcase

      if (pos == POS_HUM_CRC) begin
        fr_data_nxt  = '{temp_word: temp_r, hum_word: hum_r, crc_fail: fail_nxt};
        fr_valid_nxt = 1'b1;
        fail_nxt     = 1'b0;
        pos_nxt      = POS_TEMP_HI;
      end else begin
        pos_nxt = pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_TEMP_HI;
      crc_r      <= CRC_INIT;
      temp_r     <= '0;
      hum_r      <= '0;
      fail_r     <= 1'b0;
      fr_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      temp_r     <= temp_nxt;
      hum_r      <= hum_nxt;
      fail_r     <= fail_nxt;
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_data_r <= fr_data_nxt;
  end

  assign fr_valid = fr_valid_r;
  assign fr_data  = fr_data_r;

endmodule

// File: src/htfd_scale.sv
// raw word scaling to hundredths: product stage then divide and clamp stage
`timescale 1ns / 1ps

module htfd_scale
  import htfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fr_valid,
  input  frame_t             fr_data,
  output logic               fr_take,
  output logic               prod_valid,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [14:0] res_temp,
  output logic [13:0]        res_hum,
  output logic [15:0]        res_temp_word,
  output logic [15:0]        res_hum_word,
  output logic               res_fail
);

  logic        p_valid_r, p_valid_nxt;
  logic [30:0] t_prod_r;
  logic [29:0] h_prod_r;
  frame_t      p_frame_r;

  logic               out_valid_r, out_valid_nxt;
  logic signed [14:0] out_temp_r;
  logic [13:0]        out_hum_r;
  logic [15:0]        out_tword_r;
  logic [15:0]        out_hword_r;
  logic               out_fail_r;

  logic out_load, p_adv;

  logic [14:0] t_hi, t_q;
  logic [15:0] t_lo, h_lo;
  logic [16:0] t_sum, h_sum;
  logic [13:0] h_hi, h_q;
  logic signed [14:0] temp_c;
  logic [13:0]        hum_c;

  assign out_load    = p_valid_r && (!out_valid_r || res_ready);
  assign p_adv       = !p_valid_r || out_load;
  assign fr_take     = fr_valid && p_adv;
  assign p_valid_nxt = p_adv ? fr_valid : p_valid_r;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // x / 65535 with x = hi*65536 + lo: hi plus one when hi + lo reaches 65535
  always_comb begin
    t_hi  = t_prod_r[30:16];
    t_lo  = t_prod_r[15:0];
    t_sum = {2'b00, t_hi} + {1'b0, t_lo};
    t_q   = t_hi + 15'(t_sum >= WORD_MAX);

    h_hi  = h_prod_r[29:16];
    h_lo  = h_prod_r[15:0];
    h_sum = {3'b000, h_hi} + {1'b0, h_lo};
    h_q   = h_hi + 14'(h_sum >= WORD_MAX);

    temp_c = $signed(t_q - TEMP_OFFSET);
    if (h_q < HUM_OFFSET) begin
      hum_c = '0;
    end else if (h_q - HUM_OFFSET > HUM_MAX) begin
      hum_c = HUM_MAX;
    end else begin
      hum_c = h_q - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_take) begin
      t_prod_r  <= 31'(TEMP_SPAN) * 31'(fr_data.temp_word);
      h_prod_r  <= 30'(HUM_SPAN) * 30'(fr_data.hum_word);
      p_frame_r <= fr_data;
    end
    if (out_load) begin
      out_temp_r  <= p_frame_r.crc_fail ? '0 : temp_c;
      out_hum_r   <= p_frame_r.crc_fail ? '0 : hum_c;
      out_tword_r <= p_frame_r.temp_word;
      out_hword_r <= p_frame_r.hum_word;
      out_fail_r  <= p_frame_r.crc_fail;
    end
  end

  assign prod_valid    = p_valid_r;
  assign res_valid     = out_valid_r;
  assign res_temp      = out_temp_r;
  assign res_hum       = out_hum_r;
  assign res_temp_word = out_tword_r;
  assign res_hum_word  = out_hword_r;
  assign res_fail      = out_fail_r;

endmodule

// File: src/humidity_temp_frame_decoder.sv
// top level of the humidity and temperature reply frame decoder
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_defines.svh"

// channel   dir  payload
// in_*      in   tdata: rx_byte; tuser: frame_start
// out_*     out  tdata: temperature_centi, humidity_centi, temperature_word,
//                humidity_word; tuser: status
//
// one byte transfer per cycle while in_tready is high; the edge that takes the sixth
// byte loads the frame register, and the frame then moves through the product and
// result registers in that order before out_tvalid rises and a result can transfer
// three stage registers with their own valid bits absorb a stalled output,
// so bytes keep flowing until every stage holds a finished frame
// synchronous active-low reset clears byte position, crc and all valids

module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  // decoded result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi,
                                  // [44:29] temperature_word, [60:45] humidity_word,
                                  // [63:61] zero
  output logic [0:0]  out_tuser   // [0] status, crc mismatch
);

  // frame register to product stage
  logic   fr_valid;
  frame_t fr_data;
  logic   fr_take;
  logic   prod_valid;

  // result register fields
  logic signed [14:0] res_temp;
  logic [13:0]        res_hum;
  logic [15:0]        res_temp_word;
  logic [15:0]        res_hum_word;
  logic               res_fail;

  // byte tracking and crc checking
  htfd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_start (in_tuser[0]),
    .fr_valid (fr_valid),
    .fr_data  (fr_data),
    .fr_take  (fr_take)
  );

  // scaling to hundredths and the result register
  htfd_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .fr_valid      (fr_valid),
    .fr_data       (fr_data),
    .fr_take       (fr_take),
    .prod_valid    (prod_valid),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_temp      (res_temp),
    .res_hum       (res_hum),
    .res_temp_word (res_temp_word),
    .res_hum_word  (res_hum_word),
    .res_fail      (res_fail)
  );

  // pack result fields, lowest field first
  assign out_tdata = {3'b000, res_hum_word, res_temp_word, res_hum, res_temp};
  assign out_tuser = res_fail;

  // a crc failure forces both converted values to zero
  `HTFD_ASSERT_NOW(a_fail_zero, out_tvalid && out_tuser[0], out_tdata[28:0] == 29'd0, "crc failure with nonzero values")

  // humidity never leaves its clamp range
  `HTFD_ASSERT_NOW(a_hum_clamp, out_tvalid, out_tdata[28:15] <= 14'd10000, "humidity above clamp")

  // a new result only appears after the product stage held one
  `HTFD_ASSERT_NOW(a_out_from_prod, out_tvalid && !$past(out_tvalid), $past(prod_valid), "result without product stage")

endmodule
